// File: design/rmsp_pkg.sv
// ============================================================================
// rmsp_pkg - shared types and constants for the RMSprop update block
// Item layouts, register indexes and pipeline sizes used by the front, queue, back and top modules.
// ============================================================================
`default_nettype none

package rmsp_pkg;

  localparam int CACHE_DEPTH = 4096;                 // square-average entries
  localparam int CACHE_AW    = $clog2(CACHE_DEPTH);
  localparam int QDEPTH      = 8;                    // front-to-back queue
  localparam int QAW         = $clog2(QDEPTH);
  localparam int SQ_STEPS    = 24;                   // root digits of a 48-bit radicand
  localparam int DIV_STEPS   = 49;                   // quotient bits of the step
  localparam logic [15:0] AVG_ONE_LO = 16'd0;        // low 16 bits of 1.0 in Q1.16
  localparam logic [23:0] RATE_RESET = 24'd16777;
  localparam logic [23:0] DECAY_RESET = 24'd0;
  localparam logic [15:0] AVG_RESET  = 16'd58982;
  localparam logic [15:0] EPS_RESET  = 16'd1;

  typedef enum logic [1:0] {
    REG_INITIAL_RATE  = 2'd0,
    REG_RATE_DECAY    = 2'd1,
    REG_AVERAGE_DECAY = 2'd2,
    REG_EPSILON       = 2'd3
  } cfg_reg_t;

  // Request handed from front to back after the cache update.
  typedef struct packed {
    logic        gneg;
    logic [31:0] weight;
    logic [31:0] gmag;
    logic [31:0] cache;
    logic [23:0] rate;
    logic        last;
    logic        sat;
  } q_item_t;

  // Fields that ride along the back pipeline untouched.
  typedef struct packed {
    logic        gneg;
    logic [31:0] weight;
    logic        last;
    logic        sat;
  } meta_t;

endpackage

`default_nettype wire

// File: design/rmsp_ram.sv
// ============================================================================
// rmsp_ram - generic single-write, single-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address collision.
// ============================================================================
`default_nettype none

module rmsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/rmsp_queue.sv
// ============================================================================
// rmsp_queue - short FIFO between front and back
// Register-based queue of requests with an occupancy count.
// ============================================================================
`default_nettype none

module rmsp_queue import rmsp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_item_t push_item,
  input  wire logic    pop,
  output q_item_t      head,
  output logic         empty,
  output logic [QAW:0] count
);

  q_item_t        mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: design/rmsp_front.sv
// ============================================================================
// rmsp_front - intake and square-average update
// Accepts items, tracks the learning rate, updates the cache store with
// forwarding and hands requests to the queue.
// ============================================================================
`default_nettype none

module rmsp_front import rmsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [11:0]        in_element_index,
  input  wire logic signed [31:0] in_weight_value,
  input  wire logic signed [31:0] in_gradient,
  input  wire logic               in_last_element,
  input  wire logic               rate_load,
  input  wire logic [23:0]        rate_load_value,
  input  wire logic [23:0]        rate_decay,
  input  wire logic [15:0]        average_decay,
  input  wire logic [QAW:0]       q_count,
  output logic                    q_push,
  output q_item_t                 q_item
);

  logic accept;

  // clearing sweep after reset
  logic                clr_active_r, clr_active_nxt;
  logic [CACHE_AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [23:0] cur_rate_r, cur_rate_nxt;
  logic [48:0] rate_prod;

  // F0
  logic                v0_r;
  logic [CACHE_AW-1:0] idx0_r;
  logic [31:0]         w0_r, g0_r;
  logic                last0_r;
  logic [23:0]         rate0_r;
  logic [31:0]         gmag0;
  // F1
  logic                v1_r;
  logic [CACHE_AW-1:0] idx1_r;
  logic [31:0]         w1_r, gmag1_r, old1_r;
  logic                gneg1_r, last1_r;
  logic [23:0]         rate1_r;
  logic [46:0]         sq1_r;
  // F2
  logic                v2_r;
  logic [CACHE_AW-1:0] idx2_r;
  logic [31:0]         w2_r, gmag2_r, old2_r;
  logic                gneg2_r, last2_r;
  logic [23:0]         rate2_r;
  logic [63:0]         bterm2_r;

  // last three cache writes, newest at 0
  logic                h_v_r   [3];
  logic [CACHE_AW-1:0] h_idx_r [3];
  logic [31:0]         h_data_r[3];

  logic [31:0]         old_fwd, cache_w;
  logic [63:0]         acc;
  logic                cache_sat;
  logic [31:0]         ram_rdata;
  logic                ram_we;
  logic [CACHE_AW-1:0] ram_waddr;
  logic [31:0]         ram_wdata;
  logic [2:0]          inflight;

  assign inflight = 3'(v0_r) + 3'(v1_r) + 3'(v2_r);
  assign in_full  = clr_active_r ||
                    ((5'(q_count) + 5'(inflight)) >= 5'(QDEPTH));
  assign accept   = in_push && !in_full;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == CACHE_AW'(CACHE_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  // rate shrinks after the last item of a pass
  assign rate_prod = 49'(cur_rate_r) * 49'(25'h1000000 - 25'(rate_decay));
  always_comb begin
    cur_rate_nxt = cur_rate_r;
    if (rate_load) begin
      cur_rate_nxt = rate_load_value;
    end else if (accept && in_last_element) begin
      cur_rate_nxt = rate_prod[47:24];
    end
  end

  assign gmag0 = g0_r[31] ? 32'(32'd0 - g0_r) : g0_r;

  always_comb begin
    old_fwd = old2_r;
    for (int k = 2; k >= 0; k--) begin
      if (h_v_r[k] && (h_idx_r[k] == idx2_r)) begin
        old_fwd = h_data_r[k];
      end
    end
    acc       = 64'(average_decay) * 64'(old_fwd) + bterm2_r + 64'd32768;
    cache_sat = |acc[63:48];
    cache_w   = cache_sat ? 32'hFFFF_FFFF : acc[47:16];
  end

  always_comb begin
    ram_we    = clr_active_r || v2_r;
    ram_waddr = clr_active_r ? clr_addr_r : idx2_r;
    ram_wdata = clr_active_r ? 32'd0 : cache_w;
  end

  rmsp_ram #(.WIDTH(32), .DEPTH(CACHE_DEPTH)) u_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_element_index[CACHE_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign q_push = v2_r;
  always_comb begin
    q_item.gneg   = gneg2_r;
    q_item.weight = w2_r;
    q_item.gmag   = gmag2_r;
    q_item.cache  = cache_w;
    q_item.rate   = rate2_r;
    q_item.last   = last2_r;
    q_item.sat    = cache_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      cur_rate_r   <= RATE_RESET;
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        h_v_r[k] <= 1'b0;
      end
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cur_rate_r   <= cur_rate_nxt;
      v0_r         <= accept;
      v1_r         <= v0_r;
      v2_r         <= v1_r;
      h_v_r[0]     <= v2_r;
      h_v_r[1]     <= h_v_r[0];
      h_v_r[2]     <= h_v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    idx0_r  <= in_element_index[CACHE_AW-1:0];
    w0_r    <= in_weight_value;
    g0_r    <= in_gradient;
    last0_r <= in_last_element;
    rate0_r <= cur_rate_r;

    idx1_r  <= idx0_r;
    w1_r    <= w0_r;
    gneg1_r <= g0_r[31];
    gmag1_r <= gmag0;
    last1_r <= last0_r;
    rate1_r <= rate0_r;
    sq1_r   <= 47'((64'(gmag0) * 64'(gmag0)) >> 16);
    old1_r  <= ram_rdata;

    idx2_r   <= idx1_r;
    w2_r     <= w1_r;
    gneg2_r  <= gneg1_r;
    gmag2_r  <= gmag1_r;
    last2_r  <= last1_r;
    rate2_r  <= rate1_r;
    old2_r   <= old1_r;
    bterm2_r <= 64'(17'({1'b1, AVG_ONE_LO} - 17'(average_decay))) * 64'(sq1_r);

    h_idx_r[0]  <= idx2_r;
    h_data_r[0] <= cache_w;
    h_idx_r[1]  <= h_idx_r[0];
    h_data_r[1] <= h_data_r[0];
    h_idx_r[2]  <= h_idx_r[1];
    h_data_r[2] <= h_data_r[1];
  end

endmodule

`default_nettype wire

// File: design/rmsp_back.sv
// ============================================================================
// rmsp_back - square root, step division and weight update
// Digit-per-stage root and quotient pipeline ending in the result register.
// ============================================================================
`default_nettype none

module rmsp_back import rmsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire q_item_t     q_head,
  output logic             q_pop,
  input  wire logic [15:0] epsilon,
  input  wire logic        out_pop,
  output logic             out_empty,
  output logic signed [31:0] out_updated_weight,
  output logic             out_saturated,
  output logic             out_pass_end
);

  logic en;

  // root stages
  logic        sv_r    [SQ_STEPS];
  logic [25:0] srem_r  [SQ_STEPS];
  logic [23:0] sroot_r [SQ_STEPS];
  logic [47:0] srad_r  [SQ_STEPS];
  logic [55:0] sprod_r [SQ_STEPS];
  meta_t       smeta_r [SQ_STEPS];
  logic        sv_i    [SQ_STEPS];
  logic [25:0] srem_i  [SQ_STEPS];
  logic [23:0] sroot_i [SQ_STEPS];
  logic [47:0] srad_i  [SQ_STEPS];
  logic [55:0] sprod_i [SQ_STEPS];
  meta_t       smeta_i [SQ_STEPS];
  logic [25:0] srem_n  [SQ_STEPS];
  logic [23:0] sroot_n [SQ_STEPS];

  // numerator / denominator stage
  logic        nd_v_r;
  logic [24:0] nd_d_r;
  logic [48:0] nd_n_r;
  meta_t       nd_meta_r;
  logic [15:0] eps_eff;
  logic [24:0] den;
  logic [56:0] num;

  // quotient stages
  logic        dv_r    [DIV_STEPS];
  logic [24:0] drem_r  [DIV_STEPS];
  logic [48:0] dnum_r  [DIV_STEPS];
  logic [48:0] dq_r    [DIV_STEPS];
  logic [24:0] dden_r  [DIV_STEPS];
  meta_t       dmeta_r [DIV_STEPS];
  logic        dv_i    [DIV_STEPS];
  logic [24:0] drem_i  [DIV_STEPS];
  logic [48:0] dnum_i  [DIV_STEPS];
  logic [48:0] dq_i    [DIV_STEPS];
  logic [24:0] dden_i  [DIV_STEPS];
  meta_t       dmeta_i [DIV_STEPS];
  logic [24:0] drem_n  [DIV_STEPS];
  logic [48:0] dq_n    [DIV_STEPS];

  // result
  logic              out_v_r;
  logic signed [31:0] out_w_r;
  logic              out_sat_r, out_last_r;
  logic signed [50:0] w_ext, q_ext, res;
  logic              over_hi, over_lo;
  meta_t             fin_meta;

  assign en    = !out_v_r || out_pop;
  assign q_pop = en && !q_empty;

  always_comb begin
    sv_i[0]    = !q_empty;
    srem_i[0]  = '0;
    sroot_i[0] = '0;
    srad_i[0]  = {q_head.cache, 16'd0};
    sprod_i[0] = 56'(q_head.rate) * 56'(q_head.gmag);
    smeta_i[0].gneg   = q_head.gneg;
    smeta_i[0].weight = q_head.weight;
    smeta_i[0].last   = q_head.last;
    smeta_i[0].sat    = q_head.sat;
    for (int k = 1; k < SQ_STEPS; k++) begin
      sv_i[k]    = sv_r[k-1];
      srem_i[k]  = srem_r[k-1];
      sroot_i[k] = sroot_r[k-1];
      srad_i[k]  = srad_r[k-1];
      sprod_i[k] = sprod_r[k-1];
      smeta_i[k] = smeta_r[k-1];
    end
  end

  // one root digit per stage
  always_comb begin
    logic [26:0] r2;
    logic [26:0] t;
    for (int k = 0; k < SQ_STEPS; k++) begin
      r2 = {srem_i[k][24:0], srad_i[k][47:46]};
      t  = {1'b0, sroot_i[k], 2'b01};
      if (r2 >= t) begin
        srem_n[k]  = 26'(r2 - t);
        sroot_n[k] = {sroot_i[k][22:0], 1'b1};
      end else begin
        srem_n[k]  = 26'(r2);
        sroot_n[k] = {sroot_i[k][22:0], 1'b0};
      end
    end
  end

  // den = root + eps (eps of 0 taken as 1), num = (rate*|g| + den*128) >> 8
  assign eps_eff = (epsilon == 16'd0) ? 16'd1 : epsilon;
  assign den     = 25'(sroot_r[SQ_STEPS-1]) + 25'(eps_eff);
  assign num     = 57'(sprod_r[SQ_STEPS-1]) + 57'({den, 7'd0});

  always_comb begin
    dv_i[0]    = nd_v_r;
    drem_i[0]  = '0;
    dnum_i[0]  = nd_n_r;
    dq_i[0]    = '0;
    dden_i[0]  = nd_d_r;
    dmeta_i[0] = nd_meta_r;
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_i[j]    = dv_r[j-1];
      drem_i[j]  = drem_r[j-1];
      dnum_i[j]  = dnum_r[j-1];
      dq_i[j]    = dq_r[j-1];
      dden_i[j]  = dden_r[j-1];
      dmeta_i[j] = dmeta_r[j-1];
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [25:0] r2;
    for (int j = 0; j < DIV_STEPS; j++) begin
      r2 = {drem_i[j], dnum_i[j][48]};
      if (r2 >= {1'b0, dden_i[j]}) begin
        drem_n[j] = 25'(r2 - {1'b0, dden_i[j]});
        dq_n[j]   = {dq_i[j][47:0], 1'b1};
      end else begin
        drem_n[j] = 25'(r2);
        dq_n[j]   = {dq_i[j][47:0], 1'b0};
      end
    end
  end

  always_comb begin
    fin_meta = dmeta_r[DIV_STEPS-1];
    w_ext    = 51'(signed'(fin_meta.weight));
    q_ext    = signed'({2'b00, dq_r[DIV_STEPS-1]});
    res      = fin_meta.gneg ? w_ext + q_ext : w_ext - q_ext;
    over_hi  = !res[50] && (|res[49:31]);
    over_lo  = res[50] && !(&res[49:31]);
  end

  assign out_empty          = !out_v_r;
  assign out_updated_weight = out_w_r;
  assign out_saturated      = out_sat_r;
  assign out_pass_end       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sv_r[k] <= 1'b0;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_r[j] <= 1'b0;
      end
      nd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sv_r[k] <= sv_i[k];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_r[j] <= dv_i[j];
      end
      nd_v_r  <= sv_r[SQ_STEPS-1];
      out_v_r <= dv_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        srem_r[k]  <= srem_n[k];
        sroot_r[k] <= sroot_n[k];
        srad_r[k]  <= {srad_i[k][45:0], 2'b00};
        sprod_r[k] <= sprod_i[k];
        smeta_r[k] <= smeta_i[k];
      end
      nd_d_r    <= den;
      nd_n_r    <= num[56:8];
      nd_meta_r <= smeta_r[SQ_STEPS-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        drem_r[j]  <= drem_n[j];
        dnum_r[j]  <= {dnum_i[j][47:0], 1'b0};
        dq_r[j]    <= dq_n[j];
        dden_r[j]  <= dden_i[j];
        dmeta_r[j] <= dmeta_i[j];
      end
      out_w_r    <= over_hi ? 32'sh7FFF_FFFF :
                    over_lo ? 32'sh8000_0000 : res[31:0];
      out_sat_r  <= fin_meta.sat || over_hi || over_lo;
      out_last_r <= fin_meta.last;
    end
  end

endmodule

`default_nettype wire

// File: design/rmsprop_parameter_update.sv
// ============================================================================
// rmsprop_parameter_update - streaming RMSprop weight update
// Top level: configuration registers, front, request queue and back.
// ============================================================================
// Takes one weight/gradient request per clock while in_full is low and returns
// one updated weight per clock while out_pop is held, in request order. Each
// request passes 3 front stages for the cache read-modify-write (the first
// loading on the accepting edge), one queue slot, 24 root stages, one
// numerator stage, 49 quotient stages and the result register. The
// per-element square average lives in a 4096-entry RAM; after reset a
// clearing sweep writes it to zero, one entry a cycle, and in_full stays
// high until the sweep ends (configuration writes are taken during the sweep).
// Back-to-back requests to the same element are forwarded inside the front,
// so no bubble is needed. in_full also rises when the 8-deep queue plus the
// front stages would fill, i.e. when the result side is not being popped.
// cfg_ready is always high; write registers only while no request is in flight.
// ============================================================================
`default_nettype none

module rmsprop_parameter_update import rmsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request side
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [11:0]        in_element_index,
  input  wire logic signed [31:0] in_weight_value,
  input  wire logic signed [31:0] in_gradient,
  input  wire logic               in_last_element,
  // result side
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [31:0]      out_updated_weight,
  output logic                    out_saturated,
  output logic                    out_pass_end,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  logic [23:0] rate_decay_r, rate_decay_nxt;
  logic [15:0] avg_decay_r, avg_decay_nxt;
  logic [15:0] epsilon_r, epsilon_nxt;
  logic        cfg_we, rate_load;

  logic         q_push, q_pop, q_empty;
  q_item_t      q_item, q_head;
  logic [QAW:0] q_count;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // initial_rate only seeds the running rate held in the front
  always_comb begin
    rate_load      = 1'b0;
    rate_decay_nxt = rate_decay_r;
    avg_decay_nxt  = avg_decay_r;
    epsilon_nxt    = epsilon_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INITIAL_RATE:  rate_load      = 1'b1;
        REG_RATE_DECAY:    rate_decay_nxt = cfg_data;
        REG_AVERAGE_DECAY: avg_decay_nxt  = cfg_data[15:0];
        REG_EPSILON:       epsilon_nxt    = cfg_data[15:0];
        default:           rate_load      = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_decay_r <= DECAY_RESET;
      avg_decay_r  <= AVG_RESET;
      epsilon_r    <= EPS_RESET;
    end else begin
      rate_decay_r <= rate_decay_nxt;
      avg_decay_r  <= avg_decay_nxt;
      epsilon_r    <= epsilon_nxt;
    end
  end

  rmsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_element_index (in_element_index),
    .in_weight_value  (in_weight_value),
    .in_gradient      (in_gradient),
    .in_last_element  (in_last_element),
    .rate_load        (rate_load),
    .rate_load_value  (cfg_data),
    .rate_decay       (rate_decay_r),
    .average_decay    (avg_decay_r),
    .q_count          (q_count),
    .q_push           (q_push),
    .q_item           (q_item)
  );

  rmsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  rmsp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .epsilon            (epsilon_r),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_updated_weight (out_updated_weight),
    .out_saturated      (out_saturated),
    .out_pass_end       (out_pass_end)
  );

endmodule

`default_nettype wire
